/* rtl/core/sgm_pkg.sv */
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants for the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W = 8;
  localparam int MAG_W = 11;
  localparam int ROW_W = 13;   // rows run up to height + 1 while draining
  localparam int SQ_W  = 21;   // Gx^2 + Gy^2 < 2^21

  // configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 13;
  localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 1'b1;
  localparam logic [11:0]       FRAME_WIDTH_RST  = 12'd640;
  localparam logic [12:0]       FRAME_HEIGHT_RST = 13'd480;

  // input word kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel;
  } sgm_in_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_last;
  } sgm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SQRT,
    ST_DONE
  } sgm_state_t;

endpackage

/* rtl/core/sobel_gradient_magnitude.sv */
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// Streaming 3x3 Sobel edge magnitude over a raster frame, zero padded.
// ----------------------------------------------------------------------------
//   channel | dir | handshake         | word
//   in_     | in  | in_valid/in_stall | sgm_in_t  (req_type, pixel)
//   out_    | out | out_valid/out_stall | sgm_out_t (magnitude, frame_last)
//   cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
//
// A word that yields a result passes line store read, window and gradients,
// squaring, 11 steps of the bit-pair square root and output load. A word
// without one returns to idle after the read; an ignored drain word stays idle.
// Reset (synchronous) clears position, window, counters and config.
// The output register holds a result under out_stall while the next word is
// taken; in_stall is high while any word is in work and while a second result waits.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sgm_pkg::sgm_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sgm_pkg::sgm_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [sgm_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [sgm_pkg::CFG_DW-1:0]   cfg_wdata
);
  import sgm_pkg::*;

  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int WW  = CIW + 1;
  localparam int OW  = CIW + 12;
  localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << (SQ_W - 1);

  // configuration
  logic [11:0]          width_r;
  logic [12:0]          height_r;
  logic [WW-1:0]        w_eff;
  logic [ROW_W-1:0]     h_eff;
  logic [WW+ROW_W-1:0]  total;
  logic [OW-1:0]        total_m1_r;

  // control and position
  sgm_state_t           state_r, state_nxt;
  logic [CIW-1:0]       in_col_r;
  logic [ROW_W-1:0]     in_row_r;
  logic [OW-1:0]        out_idx_r;

  // window and line stores
  logic [PIX_W-1:0]     win_r [9];
  logic [PIX_W-1:0]     px_r;
  logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]   rd_data_r;

  // accept stage
  logic                 in_acc;
  logic                 wrap;
  logic [CIW-1:0]       col_a;
  logic [ROW_W-1:0]     row_a;
  logic                 is_drain;
  logic                 skip;
  logic [PIX_W-1:0]     px_a;

  // window stage
  logic [PIX_W-1:0]     sh [9];
  logic [PIX_W-1:0]     tap [9];
  logic [PIX_W-1:0]     v [9];
  logic                 col0, emit, top_off, left_off, last;
  logic [WW-1:0]        col_inc;
  logic                 col_wrap;
  logic [9:0]           gx_p, gx_n, gy_p, gy_n;
  logic signed [10:0]   gx_nxt, gy_nxt;
  logic signed [10:0]   gx_r, gy_r;
  logic                 last_r;

  // squaring and root
  logic signed [21:0]   sqx, sqy;
  logic [SQ_W-1:0]      rem_r, res_r, bit_r, trial;
  logic                 out_free;
  logic                 out_valid_r;
  sgm_out_t             out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata[11:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0)                 w_eff = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else                               w_eff = WW'(width_r);
    if (height_r == '0)                      h_eff = ROW_W'(1);
    else if (32'(height_r) > MAX_HEIGHT)     h_eff = ROW_W'(MAX_HEIGHT);
    else                                     h_eff = height_r;
    total = w_eff * h_eff;
  end

  always_ff @(posedge clk) begin
    total_m1_r <= OW'(total - 1'b1);
  end

  // ---------------------------------------------------------------- accept
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign wrap     = {1'b0, in_col_r} >= w_eff;
  assign col_a    = wrap ? '0 : in_col_r;
  assign row_a    = wrap ? in_row_r + 1'b1 : in_row_r;
  assign is_drain = in_data.req_type == REQ_DRAIN;
  assign skip     = is_drain && (row_a == '0) && (col_a == '0);
  assign px_a     = (is_drain || row_a >= h_eff) ? '0 : in_data.pixel;

  // ---------------------------------------------------------------- window
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r*3+0] = win_r[r*3+1];
      sh[r*3+1] = win_r[r*3+2];
    end
    sh[2] = rd_data_r[2*PIX_W-1:PIX_W];
    sh[5] = rd_data_r[PIX_W-1:0];
    sh[8] = px_r;

    col0 = in_col_r == '0;
    if (col0) begin
      // right edge of the row two above: last two columns plus padding
      for (int r = 0; r < 3; r++) begin
        tap[r*3+0] = win_r[r*3+1];
        tap[r*3+1] = win_r[r*3+2];
        tap[r*3+2] = '0;
      end
      emit     = in_row_r >= ROW_W'(2);
      top_off  = in_row_r <  ROW_W'(3);
      left_off = w_eff < WW'(2);
    end else begin
      for (int k = 0; k < 9; k++) tap[k] = sh[k];
      emit     = in_row_r >= ROW_W'(1);
      top_off  = in_row_r <  ROW_W'(2);
      left_off = in_col_r <  CIW'(2);
    end

    for (int k = 0; k < 9; k++) begin
      v[k] = ((top_off && k < 3) || (left_off && (k % 3) == 0)) ? '0 : tap[k];
    end

    gx_p = 10'(v[2]) + {1'b0, v[5], 1'b0} + 10'(v[8]);
    gx_n = 10'(v[0]) + {1'b0, v[3], 1'b0} + 10'(v[6]);
    gy_p = 10'(v[6]) + {1'b0, v[7], 1'b0} + 10'(v[8]);
    gy_n = 10'(v[0]) + {1'b0, v[1], 1'b0} + 10'(v[2]);
    gx_nxt = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
    gy_nxt = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});

    last     = emit && (out_idx_r >= total_m1_r);
    col_inc  = {1'b0, in_col_r} + 1'b1;
    col_wrap = col_inc >= w_eff;
  end

  // line stores: {upper, middle} per column, read on accept, written back
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= line_mem[col_a];
    end
    if (state_r == ST_READ) begin
      line_mem[in_col_r] <= {rd_data_r[PIX_W-1:0], px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_idx_r <= '0;
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else if (in_acc) begin
      in_col_r <= col_a;
      in_row_r <= row_a;
    end else if (state_r == ST_READ) begin
      if (last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_idx_r <= '0;
        for (int k = 0; k < 9; k++) win_r[k] <= '0;
      end else begin
        out_idx_r <= out_idx_r + OW'(emit);
        in_col_r  <= col_wrap ? '0 : col_inc[CIW-1:0];
        in_row_r  <= in_row_r + ROW_W'(col_wrap);
        for (int k = 0; k < 9; k++) win_r[k] <= sh[k];
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  assign sqx   = gx_r * gx_r;
  assign sqy   = gy_r * gy_r;
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= px_a;
    end
    if (state_r == ST_READ) begin
      gx_r   <= gx_nxt;
      gy_r   <= gy_nxt;
      last_r <= last;
    end
    if (state_r == ST_MUL) begin
      rem_r <= SQ_W'(sqx[19:0]) + SQ_W'(sqy[19:0]);
      res_r <= '0;
      bit_r <= SQ_TOP;
    end
    if (state_r == ST_SQRT) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // ---------------------------------------------------------------- output
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r.magnitude  <= res_r[MAG_W-1:0];
      out_data_r.frame_last <= last_r;
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !skip) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = emit ? ST_MUL : ST_IDLE;
      ST_MUL:  state_nxt = ST_SQRT;
      ST_SQRT: if (bit_r[0]) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sobel_gradient_magnitude. Words go in through a
// bursty sender, results come out against a stalling receiver, and every
// result is checked against an in-bench predictor. The predictor keeps its
// own line stores, 3x3 window and raster position. Directed frames come first,
// then mid-frame register changes and register extremes, then random frames.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int LINE_LEN      = MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_WORDS  = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sgm_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sgm_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_AW-1:0]     cfg_index = '0;
  logic [CFG_DW-1:0]     cfg_wdata = '0;

  sobel_gradient_magnitude i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor state
  // --------------------------------------------------------------------------
  logic [11:0]  frame_w_q = FRAME_WIDTH_RST;
  logic [12:0]  frame_h_q = FRAME_HEIGHT_RST;
  logic [7:0]   upper_row  [LINE_LEN];
  logic [7:0]   middle_row [LINE_LEN];
  logic [7:0]   win [9];
  int           taps [9];
  int unsigned  pos_row = 0;
  int unsigned  pos_col = 0;
  int unsigned  mag_index = 0;

  sgm_out_t     pending_mags [$];
  sgm_out_t     due;

  int           err_count = 0;
  int           words_taken = 0;
  int           mags_checked = 0;
  int           frames_closed = 0;

  bit           gaps_on = 1'b0;
  bit           rx_stall_on = 1'b0;
  int           burst_left = 0;
  int           stall_left = 0;

  initial begin
    #20_000_000;
    $display("Timed out with %0d magnitudes still due", pending_mags.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < LINE_LEN; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
  end

  function automatic int unsigned eff_width();
    if (frame_w_q == 0) return 1;
    if (frame_w_q > LINE_LEN) return LINE_LEN;
    return 32'(frame_w_q);
  endfunction

  function automatic int unsigned eff_height();
    if (frame_h_q == 0) return 1;
    if (frame_h_q > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(frame_h_q);
  endfunction

  function automatic logic [MAG_W-1:0] floor_sqrt(int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] mag_of_taps(bit top_off, bit left_off);
    int v [9];
    int gx;
    int gy;
    for (int k = 0; k < 9; k++) v[k] = taps[k];
    if (top_off) begin
      v[0] = 0; v[1] = 0; v[2] = 0;
    end
    if (left_off) begin
      v[0] = 0; v[3] = 0; v[6] = 0;
    end
    gx = (v[2] + 2 * v[5] + v[8]) - (v[0] + 2 * v[3] + v[6]);
    gy = (v[6] + 2 * v[7] + v[8]) - (v[0] + 2 * v[1] + v[2]);
    return floor_sqrt(gx * gx + gy * gy);
  endfunction

  function automatic void shift_window(logic [7:0] top, logic [7:0] centre, logic [7:0] bot);
    for (int r = 0; r < 3; r++) begin
      win[r * 3]     = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = top;
    win[5] = centre;
    win[8] = bot;
  endfunction

  // Advance the raster model by one accepted word; queue the magnitude it yields.
  function automatic bit predict_magnitude(sgm_in_t word);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    bit          drain;
    bit          emit;
    bit          frame_end;
    logic [7:0]  px;
    logic [7:0]  up;
    logic [7:0]  mid;
    sgm_out_t    res;
    w = eff_width();
    h = eff_height();
    drain = (word.req_type == REQ_DRAIN);
    emit = 1'b0;
    frame_end = 1'b0;
    px = word.pixel;
    res = '0;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    // drain with no frame under way: dropped
    if (drain && pos_row == 0 && pos_col == 0) return 1'b1;
    if (drain || pos_row >= h) px = '0;
    col = pos_col % LINE_LEN;
    up  = upper_row[col];
    mid = middle_row[col];
    if (pos_col == 0) begin
      // first column closes the right edge of the row two above
      if (pos_row >= 2) begin
        for (int k = 0; k < 3; k++) begin
          taps[k * 3]     = int'(win[k * 3 + 1]);
          taps[k * 3 + 1] = int'(win[k * 3 + 2]);
          taps[k * 3 + 2] = 0;
        end
        res.magnitude = mag_of_taps(pos_row < 3, w < 2);
        emit = 1'b1;
      end
      shift_window(up, mid, px);
    end else begin
      shift_window(up, mid, px);
      if (pos_row >= 1) begin
        for (int k = 0; k < 9; k++) taps[k] = int'(win[k]);
        res.magnitude = mag_of_taps(pos_row < 2, pos_col < 2);
        emit = 1'b1;
      end
    end
    upper_row[col]  = mid;
    middle_row[col] = px;
    if (emit) begin
      frame_end = (mag_index >= w * h - 1);
      res.frame_last = frame_end;
      pending_mags.push_back(res);
    end
    if (frame_end) begin
      pos_row = 0;
      pos_col = 0;
      mag_index = 0;
      for (int k = 0; k < 9; k++) win[k] = '0;
    end else begin
      if (emit) mag_index++;
      pos_col++;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
      end
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_mags.size() == 0) begin
        $display("%0t: unexpected result, expected none, got magnitude %0d last %0b",
                 $time, out_data.magnitude, out_data.frame_last);
        err_count++;
      end else begin
        due = pending_mags.pop_front();
        mags_checked++;
        if (out_data.magnitude !== due.magnitude) begin
          $display("%0t: magnitude mismatch, expected %0d, got %0d",
                   $time, due.magnitude, out_data.magnitude);
          err_count++;
        end
        if (out_data.frame_last !== due.frame_last) begin
          $display("%0t: frame_last mismatch, expected %0b, got %0b",
                   $time, due.frame_last, out_data.frame_last);
          err_count++;
        end
        if (due.frame_last) frames_closed++;
      end
    end
  end

  // receiver: alternating stall and free stretches of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (rx_stall_on && !out_stall) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 20);
    end
  end

  // --------------------------------------------------------------------------
  // sender and register access
  // --------------------------------------------------------------------------
  task automatic send_word(input sgm_in_t word);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!predict_magnitude(word)) words_taken++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_pixel(input logic [7:0] px);
    sgm_in_t word;
    word.req_type = REQ_PIXEL;
    word.pixel    = px;
    send_word(word);
  endtask

  task automatic send_drain();
    sgm_in_t word;
    word.req_type = REQ_DRAIN;
    word.pixel    = 8'($urandom_range(0, 255));
    send_word(word);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Block idle: valid low, nothing due, and time for a word without a result.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_mags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_w_q = val[11:0];
    else frame_h_q = val[12:0];
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DW'(h));
  endtask

  // Push the frame out; past the last row some pixel words stand in for drains.
  task automatic flush_frame(input int pixel_pct);
    while (pos_row != 0 || pos_col != 0) begin
      if (pos_row >= eff_height() && $urandom_range(0, 99) < pixel_pct)
        send_pixel(pick_pixel());
      else
        send_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_frames();
    gaps_on = 1'b0;
    rx_stall_on = 1'b0;
    set_frame(3, 2);
    // drains with no frame open are dropped
    send_drain();
    send_drain();
    send_pixel(8'd255); send_pixel(8'd0);   send_pixel(8'd255);
    send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd0);
    flush_frame(0);
    set_frame(2, 2);
    send_pixel(8'd255);
    send_drain();        // inside the frame: zero pixel
    send_pixel(8'd255);
    send_pixel(8'd0);
    flush_frame(100);    // pixels past the last row act as drains
    send_drain();        // frame closed: dropped
  endtask

  task automatic test_mid_frame_change();
    gaps_on = 1'b1;
    rx_stall_on = 1'b1;
    set_frame(6, 4);
    repeat (8) send_pixel(pick_pixel());
    // column 2 of row 1 is past the new width: wraps to row 2
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, CFG_DW'(2));
    repeat (3) send_pixel(pick_pixel());
    // frame size now below the result count: next result is the last
    wait_quiet();
    write_reg(CFG_FRAME_HEIGHT, CFG_DW'(1));
    flush_frame(50);
  endtask

  task automatic test_register_extremes();
    gaps_on = 1'b0;
    rx_stall_on = 1'b1;
    set_frame(0, 0);
    send_pixel(pick_pixel());
    flush_frame(50);
    // oversized width clamps; a narrower width then wraps the long first row
    set_frame(12'hFFF, 1);
    repeat (40) send_pixel(pick_pixel());
    wait_quiet();
    write_reg(CFG_FRAME_WIDTH, CFG_DW'(8));
    flush_frame(20);
    // oversized height clamps; a lower height then closes the frame early
    rx_stall_on = 1'b0;
    set_frame(1, 13'h1FFF);
    repeat (20) send_pixel(pick_pixel());
    wait_quiet();
    write_reg(CFG_FRAME_HEIGHT, CFG_DW'(4));
    flush_frame(50);
    wait_quiet();
  endtask

  task automatic test_random_frames();
    int          start;
    int unsigned n;
    int unsigned r;
    int unsigned w;
    int unsigned h;
    start = words_taken;
    while (words_taken - start < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 40) begin
        r = $urandom_range(0, 99);
        w = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        h = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 6);
        set_frame(w, h);
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      n = eff_width() * eff_height();
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 199);
        if (r < 6) begin
          send_drain();
        end else if (r < 9 && i > 0) begin
          break;   // cut the frame short, rest is zero padded
        end else begin
          send_pixel(pick_pixel());
        end
        if ($urandom_range(0, 199) == 0) wait_quiet();
      end
      flush_frame(30);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 2)) send_drain();
      end
    end
    wait_quiet();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_mid_frame_change();
    test_register_extremes();
    test_random_frames();
    $display("Ran %0d words through the filter; %0d magnitudes checked over %0d frames",
             words_taken, mags_checked, frames_closed);
    $display("Included drains in and out of frames, mid-frame resizes, zero and oversized sizes");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
